// File: rtl/smf_pkg.sv
// types and constants shared by the selective median filter modules
package smf_pkg;

  typedef logic [23:0] pix_t;
  typedef logic [8:0][23:0] win_t;
  typedef logic [8:0][7:0] lane_in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       end_of_row;
    logic       end_of_frame;
  } out_word_t;

  // flags and centre pixels that travel beside the median lanes
  typedef struct packed {
    logic va;
    logic vb;
    logic eof;
    pix_t cen_a;
    pix_t cen_b;
  } tag_t;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam pix_t       WHITE      = 24'hFFFFFF;
  localparam int         FIFO_DEPTH = 4;

endpackage

// File: rtl/smf_lane.sv
// one channel median of nine, three register stages
module smf_lane import smf_pkg::*; (
  input  logic       clk_i,
  input  logic       en_i,
  input  lane_in_t   pix_i,
  output logic [7:0] med_o
);

  function automatic logic [7:0] mx(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [7:0] mn(input logic [7:0] a, input logic [7:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [7:0] md3(input logic [7:0] a, input logic [7:0] b,
                                     input logic [7:0] c);
    return mx(mn(a, b), mn(mx(a, b), c));
  endfunction

  logic [2:0][7:0] lo_q, mid_q, hi_q;
  logic [2:0][7:0] lo_d, mid_d, hi_d;
  logic [7:0] p_q, q_q, s_q, med_q;

  // sort each column of three
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lo_d[k]  = mn(mn(pix_i[3*k], pix_i[3*k+1]), pix_i[3*k+2]);
      hi_d[k]  = mx(mx(pix_i[3*k], pix_i[3*k+1]), pix_i[3*k+2]);
      mid_d[k] = md3(pix_i[3*k], pix_i[3*k+1], pix_i[3*k+2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q  <= lo_d;
      mid_q <= mid_d;
      hi_q  <= hi_d;
      p_q   <= mx(mx(lo_q[0], lo_q[1]), lo_q[2]);
      q_q   <= md3(mid_q[0], mid_q[1], mid_q[2]);
      s_q   <= mn(mn(hi_q[0], hi_q[1]), hi_q[2]);
      med_q <= md3(p_q, q_q, s_q);
    end
  end

  assign med_o = med_q;

endmodule

// File: rtl/smf_fifo.sv
// output word queue, up to two pushes and one pop per cycle
module smf_fifo import smf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push0_i,
  input  logic      push1_i,
  input  out_word_t data0_i,
  input  out_word_t data1_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  localparam int PW = $clog2(FIFO_DEPTH);

  out_word_t mem_q [FIFO_DEPTH];
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [PW:0]   cnt_q, cnt_d;
  logic          pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rp_q];
  assign room_o      = (cnt_q <= (PW+1)'(FIFO_DEPTH - 2));

  always_comb begin
    wp_d  = wp_q + PW'(push0_i) + PW'(push1_i);
    rp_d  = rp_q + PW'(pop);
    cnt_d = cnt_q + (PW+1)'(push0_i) + (PW+1)'(push1_i) - (PW+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wp_q] <= data0_i;
    end
    if (push1_i) begin
      mem_q[PW'(wp_q + 1'b1)] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/selective_median_filter_3x3_unit.sv
// selective 3x3 median filter, top level
//
//  channel  | handshake           | word
//  ---------+---------------------+-----------------------------
//  config   | cfg_we_i            | cfg_idx_i, cfg_data_i
//  input    | in_valid_i/ready_o  | in_data_i (kind, rgb)
//  output   | out_valid_o/ready_i | out_data_o (rgb, eor, eof)
//
// one word accepted per cycle while the output queue has room; results,
// two on the last column of a row, pass through the two line stores (one
// read port each, read at acceptance, written back at the next advance),
// the window, the three-stage median lanes and the output queue. the whole
// pipe stalls when the four-entry output queue lacks room for two words.
// reset clears counters, window and queue; line store contents are left as they are.
module selective_median_filter_3x3_unit import smf_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_data_o
);

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam logic [WW-1:0] W_RST = WW'((MAX_WIDTH < 640) ? MAX_WIDTH : 640);

  logic [WW-1:0] w_q;
  logic [15:0]   h_q;
  logic [CW-1:0] c_q, c_d, cc;
  logic [15:0]   r_q, r_d;
  logic          adv, acc, drop, issue, wrap;
  logic [31:0]   wdat;

  // stage 1
  pix_t          mem_up [MAX_WIDTH];
  pix_t          mem_lo [MAX_WIDTH];
  pix_t          up_rd_q, lo_rd_q, s1_pix_q;
  logic          s1_v_q, s1_flush_q, s1_r2_q, s1_ea_q, s1_eb_q, s1_lsel_q, s1_eof_q;
  logic [CW-1:0] s1_c_q;
  logic [2:0][23:0] wc_q [3];
  logic [2:0][23:0] newcol, left;

  // job and lane stages
  win_t     ja_q, jb_q;
  tag_t     tj_q;
  tag_t     tp_q [3];
  lane_in_t la_in [3];
  lane_in_t lb_in [3];
  logic [7:0] ma [3];
  logic [7:0] mb [3];
  out_word_t  res_a, res_b;
  logic       room;

  assign adv        = room;
  assign in_ready_o = adv;
  assign acc        = in_valid_i && in_ready_o;

  // configuration, sizes kept already clamped
  assign wdat = {21'd0, cfg_data_i[10:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= W_RST;
      h_q <= 16'd480;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_WIDTH) begin
        if (wdat < 32'd2) begin
          w_q <= WW'(2);
        end else if (wdat > 32'(MAX_WIDTH)) begin
          w_q <= WW'(MAX_WIDTH);
        end else begin
          w_q <= WW'(wdat);
        end
      end else if (cfg_idx_i == REG_HEIGHT) begin
        h_q <= (cfg_data_i < 16'd2) ? 16'd2 : cfg_data_i;
      end
    end
  end

  // position of the incoming word
  always_comb begin
    cc    = (WW'(c_q) >= w_q) ? '0 : c_q;
    drop  = in_data_i.kind ? (r_q != h_q) : (r_q >= h_q);
    issue = acc && !drop;
    wrap  = (WW'(WW'(cc) + 1'b1) == w_q);
    c_d   = c_q;
    r_d   = r_q;
    if (issue) begin
      if (wrap) begin
        c_d = '0;
        r_d = (r_q == h_q) ? 16'd0 : r_q + 16'd1;
      end else begin
        c_d = CW'(cc + 1'b1);
      end
    end
    if (cfg_we_i && (cfg_idx_i == REG_WIDTH || cfg_idx_i == REG_HEIGHT)) begin
      c_d = '0;
      r_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
      r_q <= '0;
    end else begin
      c_q <= c_d;
      r_q <= r_d;
    end
  end

  // line stores: read at acceptance, rotated at the next advance
  always_ff @(posedge clk_i) begin
    if (issue) begin
      up_rd_q <= mem_up[cc];
      lo_rd_q <= mem_lo[cc];
    end
    if (adv && s1_v_q && !s1_flush_q) begin
      mem_up[s1_c_q] <= lo_rd_q;
      mem_lo[s1_c_q] <= s1_pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_flush_q <= in_data_i.kind;
      s1_pix_q   <= {in_data_i.pixel_red, in_data_i.pixel_green, in_data_i.pixel_blue};
      s1_c_q     <= cc;
      s1_r2_q    <= (r_q >= 16'd2);
      s1_ea_q    <= (r_q != 16'd0) && (cc != '0);
      s1_eb_q    <= (r_q != 16'd0) && wrap;
      s1_lsel_q  <= (cc == CW'(1));
      s1_eof_q   <= (r_q == h_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= issue;
    end
  end

  // new window column, index 0 top, 2 bottom
  always_comb begin
    newcol[0] = s1_flush_q ? up_rd_q : (s1_r2_q ? up_rd_q : lo_rd_q);
    newcol[1] = lo_rd_q;
    newcol[2] = s1_flush_q ? lo_rd_q : s1_pix_q;
    left      = s1_lsel_q ? wc_q[2] : wc_q[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        wc_q[k] <= '0;
      end
    end else if (adv && s1_v_q) begin
      wc_q[0] <= wc_q[1];
      wc_q[1] <= wc_q[2];
      wc_q[2] <= newcol;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ja_q <= {newcol, wc_q[2], left};
      jb_q <= {newcol, newcol, wc_q[2]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tj_q <= '0;
      for (int k = 0; k < 3; k++) begin
        tp_q[k] <= '0;
      end
    end else if (adv) begin
      tj_q.va    <= s1_v_q && s1_ea_q;
      tj_q.vb    <= s1_v_q && s1_eb_q;
      tj_q.eof   <= s1_eof_q;
      tj_q.cen_a <= wc_q[2][1];
      tj_q.cen_b <= newcol[1];
      tp_q[0]    <= tj_q;
      tp_q[1]    <= tp_q[0];
      tp_q[2]    <= tp_q[1];
    end
  end

  // one lane per color channel for each of the two result slots
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        la_in[ch][k] = ja_q[k][23-8*ch -: 8];
        lb_in[ch][k] = jb_q[k][23-8*ch -: 8];
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    smf_lane u_lane_a (
      .clk_i (clk_i),
      .en_i  (adv),
      .pix_i (la_in[ch]),
      .med_o (ma[ch])
    );
    smf_lane u_lane_b (
      .clk_i (clk_i),
      .en_i  (adv),
      .pix_i (lb_in[ch]),
      .med_o (mb[ch])
    );
  end

  // merge: median only where the centre is white
  always_comb begin
    if (tp_q[2].cen_a == WHITE) begin
      res_a.out_red   = ma[0];
      res_a.out_green = ma[1];
      res_a.out_blue  = ma[2];
    end else begin
      {res_a.out_red, res_a.out_green, res_a.out_blue} = tp_q[2].cen_a;
    end
    res_a.end_of_row   = 1'b0;
    res_a.end_of_frame = 1'b0;
    if (tp_q[2].cen_b == WHITE) begin
      res_b.out_red   = mb[0];
      res_b.out_green = mb[1];
      res_b.out_blue  = mb[2];
    end else begin
      {res_b.out_red, res_b.out_green, res_b.out_blue} = tp_q[2].cen_b;
    end
    res_b.end_of_row   = 1'b1;
    res_b.end_of_frame = tp_q[2].eof;
  end

  smf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push0_i     (adv && (tp_q[2].va || tp_q[2].vb)),
    .push1_i     (adv && tp_q[2].va && tp_q[2].vb),
    .data0_i     (tp_q[2].va ? res_a : res_b),
    .data1_i     (res_b),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == REG_WIDTH || cfg_idx_i == REG_HEIGHT)
    |=> (c_q == '0) && (r_q == 16'd0))
    else $error("frame position not cleared by register write");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_q <= h_q)
    else $error("row counter past flush row");

  a_eof_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.end_of_frame |-> out_data_o.end_of_row)
    else $error("end of frame without end of row");

  a_slot_b_with_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tp_q[2].vb |-> tp_q[2].va)
    else $error("row end word without its column word");

endmodule

// File: tb/tb_top.sv
// testbench for the selective 3x3 median filter: directed frames, random frames, stalls
`timescale 1ns / 100ps

module tb_top;
  import smf_pkg::*;

  localparam int MAXW = 1024;
  localparam int CYCLE_LIMIT = 2000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = REG_WIDTH;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_word_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_word_t   out_data_o;

  selective_median_filter_3x3_unit u_top (.*);

  initial forever #6 clk_i = ~clk_i;

  // filter predictor state
  int unsigned fw_width, fw_height;
  pix_t  upper_row [MAXW];
  pix_t  lower_row [MAXW];
  pix_t  win_col [3][3];
  int unsigned col_pos, row_pos;
  out_word_t pending_q [$];

  int errors = 0, mismatches = 0, words_seen = 0, cycles = 0;
  bit sender_idle_on = 1'b1, sink_idle_on = 1'b1, sink_hold = 1'b0;
  int  hold_cycles = 0;

  function automatic int unsigned eff_w();
    if (fw_width < 2) return 2;
    if (fw_width > MAXW) return MAXW;
    return fw_width;
  endfunction

  function automatic int unsigned eff_h();
    return fw_height < 2 ? 2 : fw_height;
  endfunction

  function automatic logic [7:0] med9(logic [7:0] v [9]);
    logic [7:0] t;
    for (int i = 0; i < 9; i++)
      for (int j = 0; j < 8 - i; j++)
        if (v[j] > v[j+1]) begin
          t = v[j]; v[j] = v[j+1]; v[j+1] = t;
        end
    return v[4];
  endfunction

  function automatic out_word_t filtered(pix_t lc [3], pix_t cc [3], pix_t rc [3],
                                         logic eor, logic eof);
    out_word_t o;
    logic [7:0] v [9];
    logic [7:0] ch [3];
    for (int k = 0; k < 3; k++) begin
      if (cc[1] == WHITE) begin
        for (int i = 0; i < 3; i++) begin
          v[i]   = lc[i][23-8*k -: 8];
          v[3+i] = cc[i][23-8*k -: 8];
          v[6+i] = rc[i][23-8*k -: 8];
        end
        ch[k] = med9(v);
      end else ch[k] = cc[1][23-8*k -: 8];
    end
    o.out_red = ch[0]; o.out_green = ch[1]; o.out_blue = ch[2];
    o.end_of_row = eor; o.end_of_frame = eof;
    return o;
  endfunction

  task automatic predict_word(in_word_t w);
    int unsigned wd, ht, r, c;
    pix_t top, mid, bot, pix;
    pix_t a [3], b [3], z [3];
    wd = eff_w(); ht = eff_h(); r = row_pos; c = col_pos;
    pix = {w.pixel_red, w.pixel_green, w.pixel_blue};
    if (c >= wd) c = 0;
    if (!w.kind && r >= ht) return;
    if (w.kind && r != ht) return;
    if (!w.kind) begin
      mid = lower_row[c];
      top = (r >= 2) ? upper_row[c] : mid;
      bot = pix;
      upper_row[c] = lower_row[c];
      lower_row[c] = pix;
    end else begin
      top = upper_row[c]; mid = lower_row[c]; bot = mid;
    end
    win_col[0] = win_col[1]; win_col[1] = win_col[2];
    win_col[2][0] = top; win_col[2][1] = mid; win_col[2][2] = bot;
    b = win_col[1]; z = win_col[2];
    if (r >= 1) begin
      if (c >= 1) begin
        if (c == 1) a = win_col[1];
        else a = win_col[0];
        pending_q.push_back(filtered(a, b, z, 1'b0, 1'b0));
      end
      if (c == wd - 1) pending_q.push_back(filtered(b, z, z, 1'b1, r == ht));
    end
    c++;
    if (c >= wd) begin
      c = 0;
      r = (r == ht) ? 0 : r + 1;
    end
    col_pos = c; row_pos = r;
  endtask

  // sender: one word, random bursts of idle first
  task automatic send_word(logic kind, pix_t p);
    in_word_t w;
    if (sender_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    w.kind = kind;
    {w.pixel_red, w.pixel_green, w.pixel_blue} = p;
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    predict_word(w);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_WIDTH) begin
      fw_width = val[10:0];
      col_pos = 0; row_pos = 0;
    end else if (idx == REG_HEIGHT) begin
      fw_height = val;
      col_pos = 0; row_pos = 0;
    end
    @(posedge clk_i);
  endtask

  function automatic pix_t rand_pix(int white_pct);
    if ($urandom_range(0, 99) < white_pct) return WHITE;
    return 24'($urandom);
  endfunction

  // full frame with flush; noise optionally slips in misplaced words
  task automatic run_frame(int white_pct, bit noisy);
    int unsigned wd, ht;
    wd = eff_w(); ht = eff_h();
    for (int r = 0; r < ht; r++)
      for (int c = 0; c < wd; c++) begin
        if (noisy && $urandom_range(0, 19) == 0) send_word(1'b1, 24'($urandom));
        send_word(1'b0, rand_pix(white_pct));
      end
    if (noisy) send_word(1'b0, rand_pix(50));
    for (int c = 0; c < wd; c++) send_word(1'b1, 24'($urandom));
  endtask

  task automatic test_directed();
    write_reg(REG_WIDTH, 16'd2);
    write_reg(REG_HEIGHT, 16'd2);
    send_word(1'b0, WHITE); send_word(1'b0, 24'h000000);
    send_word(1'b0, 24'hFFFFFE); send_word(1'b0, WHITE);
    send_word(1'b1, '0); send_word(1'b1, WHITE);
    drain();
    // out-of-range sizes clamp to 2
    write_reg(REG_WIDTH, 16'd0);
    write_reg(REG_HEIGHT, 16'd1);
    send_word(1'b1, '0);                           // flush too early
    send_word(1'b0, WHITE); send_word(1'b0, 24'h7F80FF);
    send_word(1'b0, 24'h01FE55); send_word(1'b0, WHITE);
    send_word(1'b0, 24'h123456);                   // dropped while awaiting flush
    send_word(1'b1, '0); send_word(1'b1, '0);
    drain();
    write_reg(REG_WIDTH, 16'd3);
    write_reg(REG_HEIGHT, 16'd3);
    run_frame(60, 1'b0);
    drain();
    write_reg(2'd3, 16'hFFFF);                     // unknown index ignored
  endtask

  task automatic test_random_frames();
    int sent = 0;
    while (sent < 460) begin
      write_reg(REG_WIDTH, 16'($urandom_range(2, 9)));
      write_reg(REG_HEIGHT, 16'($urandom_range(2, 6)));
      run_frame($urandom_range(10, 70), $urandom_range(0, 2) == 0);
      sent += eff_w() * (eff_h() + 1);
      drain();
    end
  endtask

  task automatic test_extremes();
    // 2047 clamps to the maximum: a partial first row gives no words
    write_reg(REG_HEIGHT, 16'd2);
    write_reg(REG_WIDTH, 16'd2047);
    for (int c = 0; c < 40; c++) send_word(1'b0, rand_pix(30));
    drain();
    write_reg(REG_WIDTH, 16'd1024);
    write_reg(REG_HEIGHT, 16'hFFFF);
    write_reg(REG_WIDTH, 16'd2);
    write_reg(REG_HEIGHT, 16'd2);
    run_frame(50, 1'b0);
    drain();
  endtask

  task automatic test_back_pressure();
    write_reg(REG_WIDTH, 16'd5);
    write_reg(REG_HEIGHT, 16'd4);
    hold_cycles = 200;
    sink_hold = 1'b1;
    sender_idle_on = 1'b0;
    run_frame(50, 1'b0);
    drain();
  endtask

  task automatic test_no_idle();
    sender_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    write_reg(REG_WIDTH, 16'd7);
    write_reg(REG_HEIGHT, 16'd5);
    run_frame(40, 1'b0);
    drain();
  endtask

  // receiver: ready with random bursts of stall, plus one long hold
  initial begin
    @(posedge rst_ni);
    forever begin
      if (sink_hold) begin
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        sink_hold = 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_seen++;
      if (pending_q.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_data_o);
      end else begin
        exp_w = pending_q.pop_front();
        if (out_data_o !== exp_w) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected r%h g%h b%h eor%b eof%b, got r%h g%h b%h eor%b eof%b",
                     exp_w.out_red, exp_w.out_green, exp_w.out_blue, exp_w.end_of_row,
                     exp_w.end_of_frame, out_data_o.out_red, out_data_o.out_green,
                     out_data_o.out_blue, out_data_o.end_of_row, out_data_o.end_of_frame);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    fw_width = 640; fw_height = 480; col_pos = 0; row_pos = 0;
    for (int i = 0; i < 3; i++) for (int j = 0; j < 3; j++) win_col[i][j] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_frames();
    test_extremes();
    test_back_pressure();
    test_no_idle();
    if (pending_q.size() != 0) begin
      errors += pending_q.size();
      $display("%0d expected words never arrived", pending_q.size());
    end
    $display("covered clamped sizes, noise and early flushes, long output stall");
    $display("%0d filtered words checked, %0d mismatches", words_seen, mismatches);
    if (errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

// File: files.f
rtl/smf_pkg.sv
rtl/smf_lane.sv
rtl/smf_fifo.sv
rtl/selective_median_filter_3x3_unit.sv
tb/tb_top.sv
